[hw/rtl/pltm_pkg.sv]
// ----------------------------------------------------------------------------
// Point light table package
// Shared widths, operation codes, table entry layout and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pltm_pkg;

  localparam int MAX_LIGHTS = 32;
  localparam int IDX_W      = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int CNT_W      = $clog2(MAX_LIGHTS + 1);

  localparam int FUNC_W    = 2;
  localparam int POS_W     = 20;
  localparam int REACH_W   = 16;
  localparam int COL_W     = 10;
  localparam int KIND_W    = 3;
  localparam int MULT_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam int MAXD_W  = REACH_W + 1;
  localparam int DIFF_W  = POS_W + 1;
  localparam int D2_W    = 2 * DIFF_W + 2;
  localparam int MOP_W   = 24;
  localparam int MUL_W   = 2 * MOP_W;
  localparam int Q_W     = 16;
  localparam int P_W     = Q_W + 1;
  localparam int CSUM_W  = COL_W + 2;
  localparam int SUM_W   = P_W + CSUM_W + CNT_W;
  localparam int NUM_W   = SUM_W + 1;
  localparam int SCALE_W = MAXD_W + 2;

  // Division of the scaled result by three uses a reciprocal multiply. The
  // reciprocal is rounded up, which stays exact for dividends below 2^19; the
  // scaled result never reaches 2^17.
  localparam int NHI_W  = NUM_W - 16;
  localparam int RCP_SH = 20;
  localparam logic [RCP_SH-1:0] RECIP3 = 20'd349526;

  localparam int DIVD_W      = 64;
  localparam int DIVS_W      = 32;
  localparam int DIV_STEPS   = DIVS_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int SQRT_IN_W   = D2_W;
  localparam int SQRT_OUT_W  = SQRT_IN_W / 2;
  localparam int SQRT_REM_W  = SQRT_OUT_W + 2;
  localparam int SQRT_STEPS  = SQRT_OUT_W;
  localparam int SQRT_CNT_W  = $clog2(SQRT_STEPS);

  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  localparam logic [KIND_W-1:0] KIND_DARK       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FOG        = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FOG_ALWAYS = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z = 2'd2;

  // Fog margin of 15 world units in 1/16 unit steps.
  localparam logic [MAXD_W-1:0] FOG_PAD  = 17'd240;
  localparam logic [P_W-1:0]    PROD_ONE = 17'h10000;

  // Multiplier operand selects.
  localparam int MS_W = 4;
  localparam logic [MS_W-1:0] MS_HOLD  = 4'd0;
  localparam logic [MS_W-1:0] MS_DX    = 4'd1;
  localparam logic [MS_W-1:0] MS_DY    = 4'd2;
  localparam logic [MS_W-1:0] MS_DZ    = 4'd3;
  localparam logic [MS_W-1:0] MS_MAXD2 = 4'd4;
  localparam logic [MS_W-1:0] MS_R2    = 4'd5;
  localparam logic [MS_W-1:0] MS_CS    = 4'd6;
  localparam logic [MS_W-1:0] MS_PQ    = 4'd7;
  localparam logic [MS_W-1:0] MS_SQ    = 4'd8;

  // Divider operand selects.
  localparam int DS_W = 2;
  localparam logic [DS_W-1:0] DS_COLOUR = 2'd0;
  localparam logic [DS_W-1:0] DS_RATIO  = 2'd1;

  // Square root operand selects.
  localparam logic SQ_D2   = 1'b0;
  localparam logic SQ_QUOT = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [POS_W-1:0]   pos_z;
    logic [REACH_W-1:0] reach;
    logic [COL_W-1:0]   red;
    logic [COL_W-1:0]   green;
    logic [COL_W-1:0]   blue;
    logic [KIND_W-1:0]  kind;
  } light_t;

  localparam int LIGHT_W = $bits(light_t);

  typedef struct packed {
    logic            load;
    logic            cnt_clr;
    logic            cnt_inc;
    logic            idx_clr;
    logic            idx_inc;
    logic [MS_W-1:0] mul_sel;
    logic            d2_clr;
    logic            d2_acc;
    logic            scale_max;
    logic            scale_sqrt;
    logic            div_start;
    logic [DS_W-1:0] div_sel;
    logic            sqrt_start;
    logic            sqrt_sel;
    logic            col_ld;
    logic [1:0]      chan;
    logic            prod_init;
    logic            prod_ld;
    logic            sum_acc;
    logic            ram_we;
    logic            out_fire;
    logic            out_acc;
    logic            out_query;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              cnt_zero;
    logic              idx_last;
    logic              far;
    logic              near;
    logic              fog;
    logic              dark;
    logic              div_busy;
    logic              sqrt_busy;
  } dp_sts_t;

endpackage

[hw/rtl/pltm_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pltm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/pltm_div.sv]
// ----------------------------------------------------------------------------
// Restoring divider
// One quotient bit per cycle. The upper half of the dividend must be below
// the divisor, so the quotient always fits in the low half.
// ----------------------------------------------------------------------------
module pltm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pltm_pkg::DIVD_W-1:0] dividend,
  input  logic [pltm_pkg::DIVS_W-1:0] divisor,
  output logic                       busy,
  output logic [pltm_pkg::DIVS_W-1:0] quot
);
  import pltm_pkg::*;

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIVS_W-1:0]    rem_r, rem_nxt;
  logic [DIVS_W-1:0]    quo_r, quo_nxt;
  logic [DIVS_W-1:0]    dvs_r;
  logic [DIVS_W:0]      trial;
  logic                 fits;

  always_comb begin
    trial   = {rem_r, quo_r[DIVS_W-1]};
    fits    = trial >= {1'b0, dvs_r};
    rem_nxt = fits ? DIVS_W'(trial - {1'b0, dvs_r}) : trial[DIVS_W-1:0];
    quo_nxt = {quo_r[DIVS_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DIVD_W-1 -: DIVS_W];
      quo_r <= dividend[DIVS_W-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;

endmodule

[hw/rtl/pltm_sqrt.sv]
// ----------------------------------------------------------------------------
// Integer square root
// Digit-by-digit root, one result bit per cycle, floor of the root.
// ----------------------------------------------------------------------------
module pltm_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pltm_pkg::SQRT_IN_W-1:0]  radicand,
  output logic                           busy,
  output logic [pltm_pkg::SQRT_OUT_W-1:0] root
);
  import pltm_pkg::*;

  logic                    busy_r;
  logic [SQRT_CNT_W-1:0]   cnt_r;
  logic [SQRT_IN_W-1:0]    rad_r;
  logic [SQRT_REM_W-1:0]   rem_r, rem_nxt;
  logic [SQRT_OUT_W-1:0]   root_r, root_nxt;
  logic [SQRT_REM_W+1:0]   rem2;
  logic [SQRT_REM_W+1:0]   trial;
  logic                    fits;

  always_comb begin
    rem2     = {rem_r, rad_r[SQRT_IN_W-1 -: 2]};
    trial    = (SQRT_REM_W + 2)'({root_r, 2'b01});
    fits     = rem2 >= trial;
    rem_nxt  = fits ? SQRT_REM_W'(rem2 - trial) : SQRT_REM_W'(rem2);
    root_nxt = {root_r[SQRT_OUT_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[SQRT_IN_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

[hw/rtl/pltm_dp.sv]
// ----------------------------------------------------------------------------
// Point light table datapath
// Operand latches, camera registers, the light table, one shared multiplier,
// the divider and square root units, accumulators and the result register.
// ----------------------------------------------------------------------------
module pltm_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pltm_pkg::dp_cmd_t             cmd,
  output pltm_pkg::dp_sts_t             sts,
  input  logic                          cfg_we,
  input  logic [pltm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pltm_pkg::POS_W-1:0]     cfg_wdata,
  input  logic [pltm_pkg::FUNC_W-1:0]    in_func,
  input  logic [pltm_pkg::POS_W-1:0]     in_pos_x,
  input  logic [pltm_pkg::POS_W-1:0]     in_pos_y,
  input  logic [pltm_pkg::POS_W-1:0]     in_pos_z,
  input  logic [pltm_pkg::REACH_W-1:0]   in_reach,
  input  logic [pltm_pkg::COL_W-1:0]     in_red,
  input  logic [pltm_pkg::COL_W-1:0]     in_green,
  input  logic [pltm_pkg::COL_W-1:0]     in_blue,
  input  logic [pltm_pkg::KIND_W-1:0]    in_kind,
  output logic                          out_valid,
  output logic [pltm_pkg::MULT_W-1:0]    out_multiplier,
  output logic                          out_accepted
);
  import pltm_pkg::*;

  function automatic logic [DIFF_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
    logic [DIFF_W-1:0] d;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    return d[DIFF_W-1] ? DIFF_W'(~d + 1'b1) : d;
  endfunction

  // Camera and latched item.
  logic [POS_W-1:0]   cam_x_r, cam_y_r, cam_z_r;
  logic [FUNC_W-1:0]  func_r;
  logic [POS_W-1:0]   px_r, py_r, pz_r;
  logic [REACH_W-1:0] reach_r;
  logic [COL_W-1:0]   col_r [3];
  logic [KIND_W-1:0]  kind_r;

  // Working registers.
  logic [CNT_W-1:0]   count_r;
  logic [IDX_W-1:0]   idx_r;
  logic [MUL_W-1:0]   mul_r;
  logic [D2_W-1:0]    d2_r;
  logic [MAXD_W-1:0]  scale_r;
  logic [COL_W-1:0]   new_col_r [3];
  logic [P_W-1:0]     prod_r;
  logic [SUM_W-1:0]   sum_r;
  logic               out_valid_r;
  logic [MULT_W-1:0]  out_mult_r;
  logic               out_acc_r;

  logic [LIGHT_W-1:0] ram_rdata;
  light_t             ent;
  light_t             wr_ent;
  logic               is_q;
  logic [POS_W-1:0]   pa_x, pa_y, pa_z, pb_x, pb_y, pb_z;
  logic [DIFF_W-1:0]  adx, ady, adz;
  logic [MAXD_W-1:0]  maxd;
  logic [MOP_W-1:0]   mop_a, mop_b;
  logic [CSUM_W-1:0]  colsum;
  logic [Q_W-1:0]     q;
  logic [P_W-1:0]     inv_q;
  logic [SCALE_W-1:0] scale_fade;
  logic [MAXD_W-1:0]  scale_sq;
  logic [NUM_W-1:0]   num;
  logic [NHI_W+RCP_SH-1:0] third_prod;
  logic [NHI_W-1:0]   third;
  logic [DIVD_W-1:0]  div_dvd;
  logic [DIVS_W-1:0]  div_dvs;
  logic [DIVS_W-1:0]  div_quot;
  logic               div_busy;
  logic [SQRT_IN_W-1:0]  sqrt_in;
  logic [SQRT_OUT_W-1:0] sqrt_root;
  logic               sqrt_busy;
  logic [MULT_W-1:0]  q_sat;

  assign ent  = light_t'(ram_rdata);
  assign is_q = (func_r == FUNC_QUERY);

  // A query measures from the stored light to the point, an add from the
  // new light to the camera; only the magnitude matters.
  always_comb begin
    pa_x = is_q ? ent.pos_x : px_r;
    pa_y = is_q ? ent.pos_y : py_r;
    pa_z = is_q ? ent.pos_z : pz_r;
    pb_x = is_q ? px_r : cam_x_r;
    pb_y = is_q ? py_r : cam_y_r;
    pb_z = is_q ? pz_r : cam_z_r;
    adx  = abs_diff(pa_x, pb_x);
    ady  = abs_diff(pa_y, pb_y);
    adz  = abs_diff(pa_z, pb_z);
  end

  assign maxd   = {1'b0, reach_r} + FOG_PAD;
  assign colsum = CSUM_W'(ent.red) + CSUM_W'(ent.green) + CSUM_W'(ent.blue);
  assign q      = sqrt_root[Q_W-1:0];
  assign inv_q  = PROD_ONE - P_W'(q);

  always_comb begin
    mop_a = '0;
    mop_b = '0;
    case (cmd.mul_sel)
      MS_DX: begin
        mop_a = MOP_W'(adx);
        mop_b = MOP_W'(adx);
      end
      MS_DY: begin
        mop_a = MOP_W'(ady);
        mop_b = MOP_W'(ady);
      end
      MS_DZ: begin
        mop_a = MOP_W'(adz);
        mop_b = MOP_W'(adz);
      end
      MS_MAXD2: begin
        mop_a = MOP_W'(maxd);
        mop_b = MOP_W'(maxd);
      end
      MS_R2: begin
        mop_a = MOP_W'(ent.reach);
        mop_b = MOP_W'(ent.reach);
      end
      MS_CS: begin
        mop_a = MOP_W'(col_r[cmd.chan]);
        mop_b = MOP_W'(scale_r);
      end
      MS_PQ: begin
        mop_a = MOP_W'(prod_r);
        mop_b = MOP_W'(q);
      end
      MS_SQ: begin
        mop_a = MOP_W'(inv_q);
        mop_b = MOP_W'(colsum);
      end
      default: begin
        mop_a = '0;
        mop_b = '0;
      end
    endcase
  end

  // Fade factor past three quarters of the range: 4 * (maxd - dist), capped.
  always_comb begin
    scale_fade = SCALE_W'(maxd - sqrt_root[MAXD_W-1:0]) << 2;
    scale_sq   = (scale_fade > SCALE_W'(maxd)) ? maxd : scale_fade[MAXD_W-1:0];
  end

  // Numerator of the result divided by 65536 here, by three through the
  // reciprocal multiply.
  assign num        = (NUM_W'(prod_r) << 9) + (NUM_W'(prod_r) << 8) + NUM_W'(sum_r);
  assign third_prod = (NHI_W + RCP_SH)'(num[NUM_W-1:16]) * (NHI_W + RCP_SH)'(RECIP3);
  assign third      = third_prod[RCP_SH +: NHI_W];

  always_comb begin
    div_dvd = '0;
    div_dvs = '0;
    case (cmd.div_sel)
      DS_COLOUR: begin
        div_dvd = DIVD_W'(mul_r);
        div_dvs = DIVS_W'(maxd);
      end
      DS_RATIO: begin
        div_dvd = {d2_r[DIVS_W-1:0], {DIVS_W{1'b0}}};
        div_dvs = mul_r[DIVS_W-1:0];
      end
      default: begin
        div_dvd = '0;
        div_dvs = '0;
      end
    endcase
  end

  assign sqrt_in = (cmd.sqrt_sel == SQ_QUOT) ? SQRT_IN_W'(div_quot) : d2_r;
  assign q_sat   = (|third[NHI_W-1:MULT_W]) ? {MULT_W{1'b1}} : third[MULT_W-1:0];

  pltm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quot     (div_quot)
  );

  pltm_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (sqrt_in),
    .busy     (sqrt_busy),
    .root     (sqrt_root)
  );

  assign wr_ent = '{pos_x: px_r, pos_y: py_r, pos_z: pz_r, reach: reach_r,
                    red: new_col_r[0], green: new_col_r[1], blue: new_col_r[2],
                    kind: kind_r};

  pltm_ram #(
    .WIDTH (LIGHT_W),
    .DEPTH (MAX_LIGHTS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (wr_ent),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r     <= '0;
      cam_y_r     <= '0;
      cam_z_r     <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CAMERA_X: cam_x_r <= cfg_wdata;
          CFG_CAMERA_Y: cam_y_r <= cfg_wdata;
          CFG_CAMERA_Z: cam_z_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.cnt_clr) begin
        count_r <= '0;
      end else if (cmd.cnt_inc) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
      out_valid_r <= cmd.out_fire;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      px_r     <= in_pos_x;
      py_r     <= in_pos_y;
      pz_r     <= in_pos_z;
      reach_r  <= in_reach;
      col_r[0] <= in_red;
      col_r[1] <= in_green;
      col_r[2] <= in_blue;
      kind_r   <= in_kind;
    end
    if (cmd.mul_sel != MS_HOLD) begin
      mul_r <= mop_a * mop_b;
    end
    if (cmd.d2_clr) begin
      d2_r <= '0;
    end else if (cmd.d2_acc) begin
      d2_r <= d2_r + D2_W'(mul_r);
    end
    if (cmd.scale_max) begin
      scale_r <= maxd;
    end else if (cmd.scale_sqrt) begin
      scale_r <= scale_sq;
    end
    if (cmd.col_ld) begin
      new_col_r[cmd.chan] <= div_quot[COL_W-1:0];
    end
    if (cmd.prod_init) begin
      prod_r <= PROD_ONE;
      sum_r  <= '0;
    end else begin
      if (cmd.prod_ld) begin
        prod_r <= mul_r[Q_W +: P_W];
      end
      if (cmd.sum_acc) begin
        sum_r <= sum_r + SUM_W'(mul_r);
      end
    end
    if (cmd.out_fire) begin
      out_mult_r <= cmd.out_query ? q_sat : '0;
      out_acc_r  <= cmd.out_acc;
    end
  end

  always_comb begin
    sts.func      = func_r;
    sts.full      = count_r >= CNT_W'(MAX_LIGHTS);
    sts.cnt_zero  = count_r == '0;
    sts.idx_last  = (CNT_W'(idx_r) + 1'b1) == count_r;
    sts.far       = D2_W'(d2_r) >= D2_W'(mul_r);
    sts.near      = ((MUL_W + 4)'(d2_r) << 4) <
                    (((MUL_W + 4)'(mul_r) << 3) + (MUL_W + 4)'(mul_r));
    sts.fog       = (ent.kind == KIND_FOG) || (ent.kind == KIND_FOG_ALWAYS);
    sts.dark      = ent.kind == KIND_DARK;
    sts.div_busy  = div_busy;
    sts.sqrt_busy = sqrt_busy;
  end

  assign out_valid      = out_valid_r;
  assign out_multiplier = out_mult_r;
  assign out_accepted   = out_acc_r;

endmodule

[hw/rtl/pltm_ctrl.sv]
// ----------------------------------------------------------------------------
// Point light table controller
// Sequences clear, add and query operations over the datapath.
// ----------------------------------------------------------------------------
module pltm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pltm_pkg::dp_sts_t sts,
  output pltm_pkg::dp_cmd_t cmd
);
  import pltm_pkg::*;

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE  = 5'd0;
  localparam logic [ST_W-1:0] S_DISP  = 5'd1;
  localparam logic [ST_W-1:0] S_ASQX  = 5'd2;
  localparam logic [ST_W-1:0] S_ASQY  = 5'd3;
  localparam logic [ST_W-1:0] S_ASQZ  = 5'd4;
  localparam logic [ST_W-1:0] S_AM2   = 5'd5;
  localparam logic [ST_W-1:0] S_ACHK  = 5'd6;
  localparam logic [ST_W-1:0] S_ASQRT = 5'd7;
  localparam logic [ST_W-1:0] S_ACM   = 5'd8;
  localparam logic [ST_W-1:0] S_ACD   = 5'd9;
  localparam logic [ST_W-1:0] S_ACW   = 5'd10;
  localparam logic [ST_W-1:0] S_AWR   = 5'd11;
  localparam logic [ST_W-1:0] S_QRD   = 5'd12;
  localparam logic [ST_W-1:0] S_QSQX  = 5'd13;
  localparam logic [ST_W-1:0] S_QSQY  = 5'd14;
  localparam logic [ST_W-1:0] S_QSQZ  = 5'd15;
  localparam logic [ST_W-1:0] S_QR2   = 5'd16;
  localparam logic [ST_W-1:0] S_QCHK  = 5'd17;
  localparam logic [ST_W-1:0] S_QDIV  = 5'd18;
  localparam logic [ST_W-1:0] S_QSQRT = 5'd19;
  localparam logic [ST_W-1:0] S_QACC  = 5'd20;
  localparam logic [ST_W-1:0] S_QPRD  = 5'd21;
  localparam logic [ST_W-1:0] S_QSUM  = 5'd22;
  localparam logic [ST_W-1:0] S_QFIN  = 5'd23;

  logic [ST_W-1:0] state_r, state_nxt;
  logic [1:0]      chan_r, chan_nxt;
  logic [ST_W-1:0] next_light;

  // After a light is done the walk either ends or reads the next entry.
  assign next_light = sts.idx_last ? S_QFIN : S_QRD;

  always_comb begin
    state_nxt = state_r;
    chan_nxt  = chan_r;
    cmd       = '0;
    cmd.chan  = chan_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        chan_nxt = 2'd0;
        unique case (sts.func)
          FUNC_CLEAR: begin
            cmd.cnt_clr  = 1'b1;
            cmd.out_fire = 1'b1;
            cmd.out_acc  = 1'b1;
            state_nxt    = S_IDLE;
          end
          FUNC_ADD: begin
            if (sts.full) begin
              cmd.out_fire = 1'b1;
              state_nxt    = S_IDLE;
            end else begin
              state_nxt = S_ASQX;
            end
          end
          FUNC_QUERY: begin
            cmd.prod_init = 1'b1;
            cmd.idx_clr   = 1'b1;
            state_nxt     = sts.cnt_zero ? S_QFIN : S_QRD;
          end
          default: begin
            cmd.out_fire = 1'b1;
            state_nxt    = S_IDLE;
          end
        endcase
      end
      S_ASQX: begin
        cmd.mul_sel = MS_DX;
        cmd.d2_clr  = 1'b1;
        state_nxt   = S_ASQY;
      end
      S_ASQY: begin
        cmd.mul_sel = MS_DY;
        cmd.d2_acc  = 1'b1;
        state_nxt   = S_ASQZ;
      end
      S_ASQZ: begin
        cmd.mul_sel = MS_DZ;
        cmd.d2_acc  = 1'b1;
        state_nxt   = S_AM2;
      end
      S_AM2: begin
        cmd.mul_sel = MS_MAXD2;
        cmd.d2_acc  = 1'b1;
        state_nxt   = S_ACHK;
      end
      S_ACHK: begin
        if (sts.far) begin
          cmd.out_fire = 1'b1;
          state_nxt    = S_IDLE;
        end else if (sts.near) begin
          cmd.scale_max = 1'b1;
          state_nxt     = S_ACM;
        end else begin
          cmd.sqrt_start = 1'b1;
          cmd.sqrt_sel   = SQ_D2;
          state_nxt      = S_ASQRT;
        end
      end
      S_ASQRT: begin
        if (!sts.sqrt_busy) begin
          cmd.scale_sqrt = 1'b1;
          state_nxt      = S_ACM;
        end
      end
      S_ACM: begin
        cmd.mul_sel = MS_CS;
        state_nxt   = S_ACD;
      end
      S_ACD: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_COLOUR;
        state_nxt     = S_ACW;
      end
      S_ACW: begin
        if (!sts.div_busy) begin
          cmd.col_ld = 1'b1;
          if (chan_r == 2'd2) begin
            state_nxt = S_AWR;
          end else begin
            chan_nxt  = chan_r + 1'b1;
            state_nxt = S_ACM;
          end
        end
      end
      S_AWR: begin
        cmd.ram_we   = 1'b1;
        cmd.cnt_inc  = 1'b1;
        cmd.out_fire = 1'b1;
        cmd.out_acc  = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_QRD: begin
        state_nxt = S_QSQX;
      end
      S_QSQX: begin
        if (sts.fog) begin
          cmd.idx_inc = !sts.idx_last;
          state_nxt   = next_light;
        end else begin
          cmd.mul_sel = MS_DX;
          cmd.d2_clr  = 1'b1;
          state_nxt   = S_QSQY;
        end
      end
      S_QSQY: begin
        cmd.mul_sel = MS_DY;
        cmd.d2_acc  = 1'b1;
        state_nxt   = S_QSQZ;
      end
      S_QSQZ: begin
        cmd.mul_sel = MS_DZ;
        cmd.d2_acc  = 1'b1;
        state_nxt   = S_QR2;
      end
      S_QR2: begin
        cmd.mul_sel = MS_R2;
        cmd.d2_acc  = 1'b1;
        state_nxt   = S_QCHK;
      end
      S_QCHK: begin
        // A zero reach also lands here, since no distance is below zero.
        if (sts.far) begin
          cmd.idx_inc = !sts.idx_last;
          state_nxt   = next_light;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DS_RATIO;
          state_nxt     = S_QDIV;
        end
      end
      S_QDIV: begin
        if (!sts.div_busy) begin
          cmd.sqrt_start = 1'b1;
          cmd.sqrt_sel   = SQ_QUOT;
          state_nxt      = S_QSQRT;
        end
      end
      S_QSQRT: begin
        if (!sts.sqrt_busy) begin
          state_nxt = S_QACC;
        end
      end
      S_QACC: begin
        cmd.mul_sel = sts.dark ? MS_PQ : MS_SQ;
        state_nxt   = sts.dark ? S_QPRD : S_QSUM;
      end
      S_QPRD: begin
        cmd.prod_ld = 1'b1;
        cmd.idx_inc = !sts.idx_last;
        state_nxt   = next_light;
      end
      S_QSUM: begin
        cmd.sum_acc = 1'b1;
        cmd.idx_inc = !sts.idx_last;
        state_nxt   = next_light;
      end
      S_QFIN: begin
        cmd.out_fire  = 1'b1;
        cmd.out_acc   = 1'b1;
        cmd.out_query = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chan_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      chan_r  <= chan_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

[hw/rtl/point_light_table_multiplier_top.sv]
// ----------------------------------------------------------------------------
// Point light table multiplier
// Keeps a table of up to MAX_LIGHTS point lights and answers lighting queries.
//
// An operation (clear, add or query) is transferred at a clock edge where
// start is high and busy is low. Exactly one result follows: out_valid is
// high for a single cycle with out_multiplier and out_accepted, and it is
// taken at the edge ending that cycle; the receiver cannot hold it off.
// busy drops in the same cycle the result shows, so the next operation may
// be transferred then.
// Clear, an add to a full table and an unknown operation finish at dispatch.
// An add that is dropped for distance ends at the distance check. A stored
// add takes the distance root in the square root unit only when the fade
// needs it, then runs one division for each of the three colour channels.
// A query walks the stored lights in turn: a fog light is skipped, a light
// that misses the point ends at the distance check, and one that covers it
// passes through the divider and then the square root unit.
// Camera registers are written through cfg_we, cfg_index and cfg_wdata;
// the user must write them only while idle, which the block does not
// enforce itself. Reset empties the table and clears the camera registers.
// ----------------------------------------------------------------------------
module point_light_table_multiplier_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [pltm_pkg::FUNC_W-1:0]     in_func,
  input  logic [pltm_pkg::POS_W-1:0]      in_pos_x,
  input  logic [pltm_pkg::POS_W-1:0]      in_pos_y,
  input  logic [pltm_pkg::POS_W-1:0]      in_pos_z,
  input  logic [pltm_pkg::REACH_W-1:0]    in_reach,
  input  logic [pltm_pkg::COL_W-1:0]      in_red,
  input  logic [pltm_pkg::COL_W-1:0]      in_green,
  input  logic [pltm_pkg::COL_W-1:0]      in_blue,
  input  logic [pltm_pkg::KIND_W-1:0]     in_kind,
  output logic                           out_valid,
  output logic [pltm_pkg::MULT_W-1:0]     out_multiplier,
  output logic                           out_accepted,
  input  logic                           cfg_we,
  input  logic [pltm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pltm_pkg::POS_W-1:0]      cfg_wdata
);
  import pltm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  pltm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  pltm_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_func        (in_func),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_reach       (in_reach),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_kind        (in_kind),
    .out_valid      (out_valid),
    .out_multiplier (out_multiplier),
    .out_accepted   (out_accepted)
  );

endmodule

[hw/rtl/pltm_checker.sv]
// ----------------------------------------------------------------------------
// Point light table port checker
// Watches the top level ports for ordering of transfers and results.
// ----------------------------------------------------------------------------
module pltm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [pltm_pkg::MULT_W-1:0] out_multiplier,
  input logic                       out_accepted
);
  import pltm_pkg::*;

  // A transferred operation always raises busy in the cycle after the transfer.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("operation transfer did not raise busy");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  // The result appears exactly when the operation retires.
  a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && $past(busy) |-> out_valid)
    else $error("operation retired without a result");

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_multiplier == '0)
    else $error("rejected operation returned a nonzero multiplier");

endmodule

bind point_light_table_multiplier_top pltm_checker u_pltm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_multiplier (out_multiplier),
  .out_accepted   (out_accepted)
);
